[design/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cartridge bank controller with clock.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

	localparam int ADDR_W    = 15;
	localparam int ROM_AW    = 21;
	localparam int OFS_W     = 14;
	localparam int BANK_W    = 7;
	localparam int RAMBANK_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 1;

	localparam int DIV_W  = 15;
	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 5;
	localparam int DAY_W  = 9;

	localparam logic [3:0]        RAM_EN_KEY = 4'hA;
	localparam logic [BANK_W-1:0] ROM_BANK_RST = BANK_W'(1);
	localparam logic [DIV_W-1:0]  DIV_MAX  = {DIV_W{1'b1}};
	localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);
	localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
	localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
	localparam logic [DAY_W-1:0]  DAY_MAX  = {DAY_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RGN_RAM_EN   = 2'd0,
		RGN_ROM_BANK = 2'd1,
		RGN_RAM_BANK = 2'd2,
		RGN_LATCH    = 2'd3
	} region_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HAS_RAM  = 2'd0,
		CFG_HAS_RTC  = 2'd1,
		CFG_RTC_HALT = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] address;
		logic [7:0]        value;
		logic [7:0]        sequencer_low;
		logic              double_speed;
	} item_t;

	typedef struct packed {
		logic [ROM_AW-1:0]    rom_address;
		logic                 ram_enabled;
		logic [RAMBANK_W-1:0] ram_bank;
	} bank_view_t;

	typedef struct packed {
		logic [DIV_W-1:0]  subsecond;
		logic [SEC_W-1:0]  seconds;
		logic [MIN_W-1:0]  minutes;
		logic [HOUR_W-1:0] hours;
		logic [DAY_W-1:0]  days;
		logic              day_carry;
		logic              halt;
	} snap_t;

endpackage

`default_nettype wire

[design/cbc_if.sv]
// ----------------------------------------------------------------------------
// cbc_item_if / cbc_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [14:0] address;
	logic [7:0]  value;
	logic [7:0]  sequencer_low;
	logic        double_speed;

	modport source (output valid, cmd, address, value, sequencer_low, double_speed,
		input ready);
	modport sink (input valid, cmd, address, value, sequencer_low, double_speed,
		output ready);
endinterface

interface cbc_result_if;
	logic        valid;
	logic        ready;
	logic [20:0] rom_address;
	logic        ram_enabled;
	logic [3:0]  ram_bank;
	logic [14:0] latched_subsecond;
	logic [5:0]  latched_seconds;
	logic [5:0]  latched_minutes;
	logic [4:0]  latched_hours;
	logic [8:0]  latched_days;
	logic        latched_day_carry;
	logic        latched_halt;

	modport source (output valid, rom_address, ram_enabled, ram_bank,
		latched_subsecond, latched_seconds, latched_minutes, latched_hours,
		latched_days, latched_day_carry, latched_halt, input ready);
	modport sink (input valid, rom_address, ram_enabled, ram_bank,
		latched_subsecond, latched_seconds, latched_minutes, latched_hours,
		latched_days, latched_day_carry, latched_halt, output ready);
endinterface

`default_nettype wire

[design/cbc_bank.sv]
// ----------------------------------------------------------------------------
// cbc_bank
// Bank registers (ROM bank, RAM bank, RAM enable) and ROM address mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_bank (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire cbc_pkg::item_t  item,
	input  wire logic            has_ram,
	output cbc_pkg::bank_view_t  view
);
	import cbc_pkg::*;

	logic [BANK_W-1:0]    rom_bank_q, rom_bank_d;
	logic [RAMBANK_W-1:0] ram_bank_q, ram_bank_d;
	logic                 ram_en_q, ram_en_d;
	region_t              region;

	assign region = region_t'(item.address[ADDR_W-1 -: 2]);

	always_comb begin
		rom_bank_d = rom_bank_q;
		ram_bank_d = ram_bank_q;
		ram_en_d   = ram_en_q;
		if (fire && item.cmd == CMD_WRITE) begin
			case (region)
				RGN_RAM_EN: begin
					if (has_ram)
						ram_en_d = (item.value[3:0] == RAM_EN_KEY);
				end
				RGN_ROM_BANK: begin
					rom_bank_d = (item.value[BANK_W-1:0] == '0) ? ROM_BANK_RST
						: item.value[BANK_W-1:0];
				end
				RGN_RAM_BANK: ram_bank_d = item.value[RAMBANK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= ROM_BANK_RST;
			ram_bank_q <= '0;
			ram_en_q   <= 1'b0;
		end else begin
			rom_bank_q <= rom_bank_d;
			ram_bank_q <= ram_bank_d;
			ram_en_q   <= ram_en_d;
		end
	end

	always_comb begin
		if (item.cmd == CMD_READ && !item.address[ADDR_W-1])
			view.rom_address = ROM_AW'(item.address);
		else if (item.cmd == CMD_READ)
			view.rom_address = {rom_bank_d, item.address[OFS_W-1:0]};
		else
			view.rom_address = {rom_bank_d, {OFS_W{1'b0}}};
		view.ram_enabled = ram_en_d;
		view.ram_bank    = ram_bank_d;
	end

	a_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rom_bank_q != '0)
		else $error("ROM bank register holds zero");

	a_bank_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && item.cmd == CMD_WRITE) |=> $stable(rom_bank_q) && $stable(ram_bank_q)
			&& $stable(ram_en_q))
		else $error("bank state changed without a register write");

	a_ram_en_no_ram: assert property (@(posedge clk) disable iff (!arst_n)
		!has_ram |=> $stable(ram_en_q))
		else $error("RAM enable changed on a cartridge without RAM");

endmodule

`default_nettype wire

[design/cbc_rtc.sv]
// ----------------------------------------------------------------------------
// cbc_rtc
// Real-time clock counter cascade and latch snapshot registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_rtc (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire cbc_pkg::item_t  item,
	input  wire logic            has_rtc,
	input  wire logic            rtc_halt,
	output cbc_pkg::snap_t       snap
);
	import cbc_pkg::*;

	logic [DIV_W-1:0]  div_q, div_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [MIN_W-1:0]  min_q, min_d;
	logic [HOUR_W-1:0] hour_q, hour_d;
	logic [DAY_W-1:0]  day_q, day_d;
	logic              carry_q, carry_d;
	logic              armed_q, armed_d;
	snap_t             snap_q, snap_d;
	logic              prescale_hit, tick_en, latch_wr;

	assign prescale_hit = item.double_speed ? (item.sequencer_low == '0)
		: (item.sequencer_low[6:0] == '0);
	assign tick_en  = fire && item.cmd == CMD_TICK && has_rtc && !rtc_halt && prescale_hit;
	assign latch_wr = fire && item.cmd == CMD_WRITE && has_rtc
		&& region_t'(item.address[ADDR_W-1 -: 2]) == RGN_LATCH;

	always_comb begin
		div_d   = div_q;
		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		day_d   = day_q;
		carry_d = carry_q;
		if (tick_en) begin
			div_d = div_q + DIV_W'(1);
			if (div_q == DIV_MAX) begin
				sec_d = (sec_q == SEC_MAX) ? '0 : sec_q + SEC_W'(1);
				if (sec_q == SEC_MAX) begin
					min_d = (min_q == MIN_MAX) ? '0 : min_q + MIN_W'(1);
					if (min_q == MIN_MAX) begin
						hour_d = (hour_q == HOUR_MAX) ? '0 : hour_q + HOUR_W'(1);
						if (hour_q == HOUR_MAX) begin
							day_d = day_q + DAY_W'(1);
							if (day_q == DAY_MAX)
								carry_d = 1'b1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		snap_d  = snap_q;
		armed_d = armed_q;
		if (latch_wr) begin
			armed_d = item.value[0];
			if (!armed_q && item.value[0])
				snap_d = '{subsecond: div_q, seconds: sec_q, minutes: min_q,
					hours: hour_q, days: day_q, day_carry: carry_q, halt: rtc_halt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= '0;
			carry_q <= 1'b0;
			armed_q <= 1'b0;
			snap_q  <= '0;
		end else begin
			div_q   <= div_d;
			sec_q   <= sec_d;
			min_q   <= min_d;
			hour_q  <= hour_d;
			day_q   <= day_d;
			carry_q <= carry_d;
			armed_q <= armed_d;
			snap_q  <= snap_d;
		end
	end

	assign snap = snap_d;

	a_carry_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q |=> carry_q)
		else $error("day carry cleared");

	a_halt_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(rtc_halt || !has_rtc) |=> $stable(div_q) && $stable(sec_q) && $stable(day_q))
		else $error("clock advanced while halted or absent");

	a_sec_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tick_en && div_q == DIV_MAX) |=> $stable(sec_q))
		else $error("seconds moved without a divider wrap");

	a_snap_on_latch: assert property (@(posedge clk) disable iff (!arst_n)
		!latch_wr |=> $stable(snap_q))
		else $error("snapshot changed without a latch write");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q <= SEC_MAX && min_q <= MIN_MAX && hour_q <= HOUR_MAX)
		else $error("clock counter out of range");

endmodule

`default_nettype wire

[design/cart_bank_controller_with_rtc.sv]
// ----------------------------------------------------------------------------
// cart_bank_controller_with_rtc
// Cartridge bank controller with real-time clock.
//
// Input channel "item" carries one transaction per ROM read, register write
// or clock tick; output channel "result" returns exactly one transaction per
// item: mapped ROM address, RAM enable, RAM bank and the latched clock.
// Configuration (has_ram, has_rtc, rtc_halt) is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// The result passes through the input register and then the bank/clock update
// into the result register; a receiver stall can hold an item in the input
// register until the result register is free. Throughput is one item per cycle
// while results are taken; the single update stage sets the rate.
// When the receiver stalls, the result holds and one more item may wait in
// the input register; item.ready then drops until the result is taken.
// Reset clears both stages, selects ROM bank 1, disables RAM and zeroes the
// clock and its snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module cart_bank_controller_with_rtc (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cbc_pkg::CFG_DW-1:0]     cfg_data,
	cbc_item_if.sink                            item,
	cbc_result_if.source                        result
);
	import cbc_pkg::*;

	logic       has_ram_q, has_rtc_q, rtc_halt_q;
	logic       s1_valid_q, out_valid_q;
	item_t      item_s1;
	logic       advance, fire;
	bank_view_t bank_view;
	bank_view_t bank_s2;
	snap_t      snap;
	snap_t      snap_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_ram_q  <= 1'b0;
			has_rtc_q  <= 1'b0;
			rtc_halt_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HAS_RAM:  has_ram_q  <= cfg_data[0];
				CFG_HAS_RTC:  has_rtc_q  <= cfg_data[0];
				CFG_RTC_HALT: rtc_halt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance    = !out_valid_q || result.ready;
	assign fire       = s1_valid_q && advance;
	assign item.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item.ready) begin
			s1_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= '{cmd: cmd_t'(item.cmd), address: item.address, value: item.value,
				sequencer_low: item.sequencer_low, double_speed: item.double_speed};
	end

	cbc_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.has_ram (has_ram_q),
		.view    (bank_view)
	);

	cbc_rtc u_rtc (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.has_rtc  (has_rtc_q),
		.rtc_halt (rtc_halt_q),
		.snap     (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			bank_s2 <= bank_view;
			snap_s2 <= snap;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.rom_address       = bank_s2.rom_address;
	assign result.ram_enabled       = bank_s2.ram_enabled;
	assign result.ram_bank          = bank_s2.ram_bank;
	assign result.latched_subsecond = snap_s2.subsecond;
	assign result.latched_seconds   = snap_s2.seconds;
	assign result.latched_minutes   = snap_s2.minutes;
	assign result.latched_hours     = snap_s2.hours;
	assign result.latched_days      = snap_s2.days;
	assign result.latched_day_carry = snap_s2.day_carry;
	assign result.latched_halt      = snap_s2.halt;

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !result.ready) |-> !item.ready)
		else $error("input accepted with both stages full");

	a_fire_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed transaction lost before the result register");

	a_out_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !advance) |=> s1_valid_q && $stable(item_s1))
		else $error("waiting transaction dropped during stall");

endmodule

`default_nettype wire

[bench/cart_bank_controller_with_rtc_tb.sv]
// ----------------------------------------------------------------------------
// cart_bank_controller_with_rtc_tb
// Self-checking bench for the cartridge bank controller with clock. A table
// of directed transactions runs first, then a short full-rate tick run with
// latch writes, then random phases under several configurations, sender
// bursts and receiver stall patterns. Every result transaction is checked
// field by field against the table or an in-bench model of the bank mapping, the clock
// cascade and the latch.
// ----------------------------------------------------------------------------

module cart_bank_controller_with_rtc_tb;

	import cbc_pkg::*;

	typedef struct packed {
		bank_view_t view;
		snap_t      latched;
	} outcome_t;

	typedef struct packed {
		logic       is_cfg;
		cfg_idx_t   idx;
		logic       cfg_v;
		item_t      stim;
		logic       typed;
		bank_view_t view;
	} row_t;

	typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

	// {has_ram, has_rtc, rtc_halt} per random phase
	localparam logic [2:0] PHASE_CFG [0:4] = '{3'b110, 3'b110, 3'b011, 3'b100, 3'b001};
	localparam int PHASE_ITEMS = 220;
	localparam int TICK_RUN = 96;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DW-1:0]    cfg_data;

	cbc_item_if   item_bus ();
	cbc_result_if result_bus ();

	cart_bank_controller_with_rtc dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_bus),
		.result    (result_bus)
	);

	// model state
	logic                 cfg_ram, cfg_rtc, cfg_halt;
	logic [BANK_W-1:0]    cur_rom_bank;
	logic [RAMBANK_W-1:0] cur_ram_bank;
	logic                 cur_ram_on;
	logic                 latch_prev;
	snap_t                rtc_run;
	snap_t                rtc_hold;

	outcome_t   awaited_results [$];
	row_t       dir_tab [$];
	int         mismatches = 0;
	sink_mode_t sink_mode = SINK_ALWAYS;
	bit         hold_req = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic outcome_t predict_result(input item_t it);
		outcome_t   o;
		logic [7:0] mask;
		if (it.cmd == CMD_WRITE) begin
			case (region_t'(it.address[14:13]))
				RGN_RAM_EN: begin
					if (cfg_ram)
						cur_ram_on = (it.value[3:0] == RAM_EN_KEY);
				end
				RGN_ROM_BANK: begin
					cur_rom_bank = it.value[6:0];
					if (cur_rom_bank == '0)
						cur_rom_bank = ROM_BANK_RST;
				end
				RGN_RAM_BANK: cur_ram_bank = it.value[3:0];
				RGN_LATCH: begin
					if (cfg_rtc) begin
						if (!latch_prev && it.value[0]) begin
							rtc_hold = rtc_run;
							rtc_hold.halt = cfg_halt;
						end
						latch_prev = it.value[0];
					end
				end
				default: ;
			endcase
		end else if (it.cmd == CMD_TICK) begin
			mask = it.double_speed ? 8'hFF : 8'h7F;
			if (cfg_rtc && !cfg_halt && (it.sequencer_low & mask) == 8'h00) begin
				rtc_run.subsecond = rtc_run.subsecond + 1'b1;
				if (rtc_run.subsecond == '0) begin
					rtc_run.seconds = (rtc_run.seconds == SEC_MAX) ? '0 : rtc_run.seconds + 1'b1;
					if (rtc_run.seconds == '0) begin
						rtc_run.minutes = (rtc_run.minutes == MIN_MAX) ? '0 :
							rtc_run.minutes + 1'b1;
						if (rtc_run.minutes == '0) begin
							rtc_run.hours = (rtc_run.hours == HOUR_MAX) ? '0 :
								rtc_run.hours + 1'b1;
							if (rtc_run.hours == '0) begin
								rtc_run.days = rtc_run.days + 1'b1;
								if (rtc_run.days == '0)
									rtc_run.day_carry = 1'b1;
							end
						end
					end
				end
			end
		end
		if (it.cmd == CMD_READ && !it.address[14])
			o.view.rom_address = {6'b0, it.address};
		else if (it.cmd == CMD_READ)
			o.view.rom_address = {cur_rom_bank, it.address[13:0]};
		else
			o.view.rom_address = {cur_rom_bank, 14'b0};
		o.view.ram_enabled = cur_ram_on;
		o.view.ram_bank = cur_ram_bank;
		o.latched = rtc_hold;
		return o;
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		it.address = $urandom_range(0, 32767);
		it.value = $urandom_range(0, 255);
		it.sequencer_low = $urandom_range(0, 255);
		it.double_speed = $urandom_range(0, 1);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.cmd = CMD_READ;
		end else if (pick < 70) begin
			it.cmd = CMD_WRITE;
			case (region_t'(it.address[14:13]))
				RGN_RAM_EN: begin
					if ($urandom_range(0, 1))
						it.value[3:0] = RAM_EN_KEY;
				end
				RGN_ROM_BANK: begin
					if ($urandom_range(0, 7) == 0)
						it.value[6:0] = '0;
				end
				RGN_LATCH: it.value[0] = ($urandom_range(0, 4) != 0) ? !latch_prev : latch_prev;
				default: ;
			endcase
		end else if (pick < 95) begin
			it.cmd = CMD_TICK;
			if ($urandom_range(0, 1)) begin
				it.sequencer_low[6:0] = '0;
				if (it.double_speed)
					it.sequencer_low[7] = 1'b0;
			end
		end else begin
			it.cmd = CMD_NONE;
		end
		return it;
	endfunction

	function automatic row_t mk_item(input cmd_t c, input logic [14:0] a, input logic [7:0] v,
		input logic [7:0] s, input logic d, input logic typed, input logic [20:0] ra,
		input logic re, input logic [3:0] rb);
		row_t r;
		r = '0;
		r.stim.cmd = c;
		r.stim.address = a;
		r.stim.value = v;
		r.stim.sequencer_low = s;
		r.stim.double_speed = d;
		r.typed = typed;
		r.view.rom_address = ra;
		r.view.ram_enabled = re;
		r.view.ram_bank = rb;
		return r;
	endfunction

	function automatic row_t mk_cfg(input cfg_idx_t idx, input logic v);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.cfg_v = v;
		return r;
	endfunction

	task automatic send_item(input item_t it, input logic typed, input bank_view_t view);
		outcome_t o;
		logic     taken;
		item_bus.valid <= 1'b1;
		item_bus.cmd <= it.cmd;
		item_bus.address <= it.address;
		item_bus.value <= it.value;
		item_bus.sequencer_low <= it.sequencer_low;
		item_bus.double_speed <= it.double_speed;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = item_bus.ready;
			@(posedge clk);
		end
		o = predict_result(it);
		if (typed)
			o.view = view;
		awaited_results.push_back(o);
	endtask

	task automatic settle();
		item_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HAS_RAM:  cfg_ram = v;
			CFG_HAS_RTC:  cfg_rtc = v;
			CFG_RTC_HALT: cfg_halt = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endtask

	initial begin : result_monitor
		outcome_t want;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result transaction with nothing pending");
				end else begin
					want = awaited_results.pop_front();
					check_field("rom_address", want.view.rom_address, result_bus.rom_address);
					check_field("ram_enabled", want.view.ram_enabled, result_bus.ram_enabled);
					check_field("ram_bank", want.view.ram_bank, result_bus.ram_bank);
					check_field("latched_subsecond", want.latched.subsecond,
						result_bus.latched_subsecond);
					check_field("latched_seconds", want.latched.seconds,
						result_bus.latched_seconds);
					check_field("latched_minutes", want.latched.minutes,
						result_bus.latched_minutes);
					check_field("latched_hours", want.latched.hours, result_bus.latched_hours);
					check_field("latched_days", want.latched.days, result_bus.latched_days);
					check_field("latched_day_carry", want.latched.day_carry,
						result_bus.latched_day_carry);
					check_field("latched_halt", want.latched.halt, result_bus.latched_halt);
				end
			end
		end
	end

	initial begin : result_sink
		int unsigned n;
		n = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			n++;
			if (hold_req) begin
				result_bus.ready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case (sink_mode)
					SINK_ALWAYS:  result_bus.ready <= 1'b1;
					SINK_RANDOM:  result_bus.ready <= ($urandom_range(0, 3) != 0);
					SINK_PATTERN: result_bus.ready <= (n % 5 != 0) && (n % 11 != 3);
					default:      result_bus.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		item_t       it;
		int unsigned burst_left;
		int unsigned gap;
		bit          gapless;
		cfg_ram = 1'b0;
		cfg_rtc = 1'b0;
		cfg_halt = 1'b0;
		cur_rom_bank = ROM_BANK_RST;
		cur_ram_bank = '0;
		cur_ram_on = 1'b0;
		latch_prev = 1'b0;
		rtc_run = '0;
		rtc_hold = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HAS_RAM;
		cfg_data <= '0;
		item_bus.valid <= 1'b0;
		item_bus.cmd <= CMD_READ;
		item_bus.address <= '0;
		item_bus.value <= '0;
		item_bus.sequencer_low <= '0;
		item_bus.double_speed <= 1'b0;

		// cmd, address, value, sequencer, double speed, typed, rom address, ram on, ram bank
		dir_tab.push_back(mk_item(CMD_READ,  15'h0000, 8'h00, 8'h00, 0, 1, 21'h000000, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_READ,  15'h3FFF, 8'h00, 8'h00, 0, 1, 21'h003FFF, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_READ,  15'h4000, 8'h00, 8'h00, 0, 1, 21'h004000, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_READ,  15'h7FFF, 8'h00, 8'h00, 0, 1, 21'h007FFF, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h0000, 8'h0A, 8'h00, 0, 1, 21'h004000, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h2000, 8'h00, 8'h00, 0, 1, 21'h004000, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h3FFF, 8'hFF, 8'h00, 0, 1, 21'h1FC000, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_READ,  15'h7FFF, 8'h00, 8'h00, 0, 1, 21'h1FFFFF, 0, 4'h0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h4000, 8'hFF, 8'h00, 0, 1, 21'h1FC000, 0, 4'hF));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h6000, 8'h01, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_NONE,  15'h7FFF, 8'hFF, 8'hFF, 1, 1, 21'h1FC000, 0, 4'hF));
		dir_tab.push_back(mk_cfg(CFG_HAS_RAM, 1'b1));
		dir_tab.push_back(mk_cfg(CFG_HAS_RTC, 1'b1));
		dir_tab.push_back(mk_cfg(CFG_UNUSED, 1'b1));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h1FFF, 8'hFA, 8'h00, 0, 1, 21'h1FC000, 1, 4'hF));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h0000, 8'h0B, 8'h00, 0, 1, 21'h1FC000, 0, 4'hF));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h0000, 8'h5A, 8'h00, 0, 1, 21'h1FC000, 1, 4'hF));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h2000, 8'h80, 8'h00, 0, 1, 21'h004000, 1, 4'hF));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h80, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h80, 1, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h00, 1, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h01, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h7FFF, 8'hFF, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h6000, 8'h00, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_cfg(CFG_RTC_HALT, 1'b1));
		dir_tab.push_back(mk_item(CMD_TICK,  15'h0000, 8'h00, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h6000, 8'h01, 8'h00, 0, 0, '0, 0, '0));
		dir_tab.push_back(mk_cfg(CFG_RTC_HALT, 1'b0));
		dir_tab.push_back(mk_cfg(CFG_HAS_RAM, 1'b0));
		dir_tab.push_back(mk_item(CMD_WRITE, 15'h0000, 8'h00, 8'h00, 0, 0, '0, 0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_cfg(dir_tab[i].idx, dir_tab[i].cfg_v);
			end else begin
				send_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].view);
			end
		end

		// full-rate ticks with a latch every few dozen
		settle();
		for (int i = 0; i < TICK_RUN; i++) begin
			if (i % 32 == 0) begin
				it = '0;
				it.cmd = CMD_WRITE;
				it.address = 15'h6000 | 15'($urandom_range(0, 8191));
				send_item(it, 1'b0, '0);
				it.value = 8'h01;
				send_item(it, 1'b0, '0);
			end
			it = '0;
			it.cmd = CMD_TICK;
			it.double_speed = $urandom_range(0, 1);
			it.sequencer_low[7] = it.double_speed ? 1'b0 : 1'($urandom_range(0, 1));
			send_item(it, 1'b0, '0);
		end

		for (int p = 0; p < 5; p++) begin
			settle();
			write_cfg(CFG_HAS_RAM, PHASE_CFG[p][2]);
			write_cfg(CFG_HAS_RTC, PHASE_CFG[p][1]);
			write_cfg(CFG_RTC_HALT, PHASE_CFG[p][0]);
			case (p)
				0: sink_mode = SINK_RANDOM;
				1: sink_mode = SINK_PATTERN;
				2: sink_mode = SINK_SPARSE;
				3: sink_mode = SINK_ALWAYS;
				default: sink_mode = SINK_RANDOM;
			endcase
			gapless = (p == 1 || p == 3);
			// receiver holds off while the sender keeps going
			if (p == 1)
				hold_req = 1'b1;
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap = gapless ? 0 : $urandom_range(1, 8);
					if (gap != 0) begin
						item_bus.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				if (n == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 1)))
					settle();
				send_item(random_item(), 1'b0, '0);
				burst_left--;
			end
		end

		settle();
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
